// File: rtl/bcg_pkg.sv
// Shared constants, types and register codes for the bilinear color gradient block.
package bcg_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int FRAME_W    = 13;
    localparam int RGB_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int NCHAN      = 3;
    localparam int HSUM_W     = FRAME_W + CHAN_W;
    localparam int NUM_W      = 2 * FRAME_W + CHAN_W;
    localparam int DEN_W      = 2 * FRAME_W;
    localparam int QUO_W      = CHAN_W;
    localparam int ARGB_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RGB_W;

    localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'hFF;

    localparam logic [FRAME_W-1:0] WIDTH_RST  = 13'd320;
    localparam logic [FRAME_W-1:0] HEIGHT_RST = 13'd240;
    localparam logic [RGB_W-1:0]   TL_RST     = 24'hFF0000;
    localparam logic [RGB_W-1:0]   TR_RST     = 24'h0000FF;
    localparam logic [RGB_W-1:0]   BL_RST     = 24'hFFFF00;
    localparam logic [RGB_W-1:0]   BR_RST     = 24'h00FF00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_TOP_LEFT     = 3'd2,
        REG_TOP_RIGHT    = 3'd3,
        REG_BOTTOM_LEFT  = 3'd4,
        REG_BOTTOM_RIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
        logic [RGB_W-1:0]   top_left_rgb;
        logic [RGB_W-1:0]   top_right_rgb;
        logic [RGB_W-1:0]   bottom_left_rgb;
        logic [RGB_W-1:0]   bottom_right_rgb;
    } cfg_t;

    // Numerator and denominator of one pixel, leaving the weighting pipeline.
    typedef struct packed {
        logic                         valid;
        logic                         outside;
        logic [NCHAN-1:0][NUM_W-1:0]  num;
        logic [DEN_W-1:0]             den;
    } front_t;

    // Quotients of one pixel, leaving the divider pipeline.
    typedef struct packed {
        logic                         valid;
        logic                         outside;
        logic [NCHAN-1:0][QUO_W-1:0]  chan;
    } div_t;

endpackage

// File: rtl/bcg_pix_if.sv
// Pixel coordinate channel with valid/ready handshake.
interface bcg_pix_if #(
    parameter int COORD_BITS = bcg_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// File: rtl/bcg_argb_if.sv
// Packed ARGB result channel with valid/ready handshake.
interface bcg_argb_if ();
    import bcg_pkg::*;

    logic              valid;
    logic              ready;
    logic [ARGB_W-1:0] argb_word;
    logic              outside_frame;

    modport source (output valid, output argb_word, output outside_frame, input ready);
    modport sink   (input valid, input argb_word, input outside_frame, output ready);
endinterface

// File: rtl/bilinear_colour_gradient_top.sv
// Top level of the four-corner bilinear color gradient generator.
//
// Usage: each transfer on the pixel channel carries one coordinate (pixel_x,
// pixel_y); for each one the color channel returns exactly one transfer with the
// packed ARGB word (alpha 0xFF) and the outside_frame flag. A coordinate outside
// the frame returns a zero word with the flag set. Results leave in input order.
//
// A pixel passes from the accepting edge through four weighting stages, eight
// divider stages (one quotient bit each) and the output register. Throughput is
// one pixel per clock while the skid register is empty; the 8-bit restoring
// divider pipeline sets the depth, and every stage advances together.
//
// Stall: a skid register behind the output register catches the one result that
// is already moving when the receiver drops ready. While it is full the whole
// pipeline holds and pixel.ready is low; pixel.ready is a register output and
// does not depend on color.ready combinationally. No result is lost or repeated.
//
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// default frame size and corner colors. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at once and must only be issued while no pixel is in
// flight; an index beyond the register list is ignored.
module bilinear_colour_gradient_top #(
    parameter int COORD_BITS = bcg_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bcg_pix_if.sink                        pixel,
    bcg_argb_if.source                     color,
    input  logic                           cfg_we,
    input  logic [bcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bcg_pkg::*;

    cfg_t   cfg_reg;
    front_t front_out;
    div_t   div_out;
    logic   adv;

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [ARGB_W-1:0] out_word_reg, skid_word_reg, res_word;
    logic              out_flag_reg, skid_flag_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width      <= WIDTH_RST;
            cfg_reg.frame_height     <= HEIGHT_RST;
            cfg_reg.top_left_rgb     <= TL_RST;
            cfg_reg.top_right_rgb    <= TR_RST;
            cfg_reg.bottom_left_rgb  <= BL_RST;
            cfg_reg.bottom_right_rgb <= BR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  cfg_reg.frame_width      <= cfg_data[FRAME_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height     <= cfg_data[FRAME_W-1:0];
                REG_TOP_LEFT:     cfg_reg.top_left_rgb     <= cfg_data[RGB_W-1:0];
                REG_TOP_RIGHT:    cfg_reg.top_right_rgb    <= cfg_data[RGB_W-1:0];
                REG_BOTTOM_LEFT:  cfg_reg.bottom_left_rgb  <= cfg_data[RGB_W-1:0];
                REG_BOTTOM_RIGHT: cfg_reg.bottom_right_rgb <= cfg_data[RGB_W-1:0];
                default:          ;
            endcase
        end
    end

    // The pipeline moves whenever the skid register is free to take a result.
    assign adv         = !skid_valid_reg;
    assign pixel.ready = adv;

    bcg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (pixel.valid),
        .pixel_x  (pixel.pixel_x),
        .pixel_y  (pixel.pixel_y),
        .cfg      (cfg_reg),
        .fout     (front_out)
    );

    bcg_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (front_out),
        .dout  (div_out)
    );

    // Inside the frame the quotients are the color; outside, the word is zero.
    assign res_word = div_out.outside ? '0
                    : {ALPHA_FULL, div_out.chan[2], div_out.chan[1], div_out.chan[0]};

    // Output register with one skid entry. When the output register is free or
    // being drained, it takes the skid entry first, else the newest result.
    // When it is held, a result leaving the pipeline goes to the skid entry.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || color.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = div_out.valid;
            end
        end
        else if (div_out.valid && adv)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            skid_word_reg <= res_word;
            skid_flag_reg <= div_out.outside;
        end
        if (!out_valid_reg || color.ready)
        begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : res_word;
            out_flag_reg <= skid_valid_reg ? skid_flag_reg : div_out.outside;
        end
    end

    assign color.valid         = out_valid_reg;
    assign color.argb_word     = out_word_reg;
    assign color.outside_frame = out_flag_reg;

    // The skid entry is only ever occupied behind a held output register.
    a_skid_behind_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("skid entry holds a result while the output register is empty");

    // The skid entry fills only after the receiver stalled a valid result.
    a_skid_fill_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !color.ready)
    ) else $error("skid entry filled without a stalled output");

    // A delivered word is zero outside the frame and carries full alpha inside.
    a_word_format: assert property (
        @(posedge clk) disable iff (!rst_n)
        color.valid |-> (color.outside_frame ? (color.argb_word == '0)
                                             : (color.argb_word[31:24] == ALPHA_FULL))
    ) else $error("result word does not match its outside_frame flag");

endmodule

// File: rtl/bcg_front.sv
// Four-stage weighting pipeline: edge weights, row blends, column blends, numerator sum.
module bcg_front #(
    parameter int COORD_BITS = bcg_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  bcg_pkg::cfg_t         cfg,
    output bcg_pkg::front_t       fout
);
    import bcg_pkg::*;

    localparam int CMP_W = (COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W;

    // Stage 1 state.
    logic               s1_valid_reg, s1_outside_reg;
    logic [FRAME_W-1:0] s1_ax_reg, s1_bx_reg, s1_ay_reg, s1_by_reg;
    logic [FRAME_W-1:0] s1_dx_reg, s1_dy_reg;
    // Stage 2 state.
    logic                         s2_valid_reg, s2_outside_reg;
    logic [NCHAN-1:0][HSUM_W-1:0] s2_top_reg, s2_bot_reg;
    logic [FRAME_W-1:0]           s2_ay_reg, s2_by_reg;
    logic [DEN_W-1:0]             s2_den_reg;
    // Stage 3 state.
    logic                        s3_valid_reg, s3_outside_reg;
    logic [NCHAN-1:0][NUM_W-1:0] s3_top_reg, s3_bot_reg;
    logic [DEN_W-1:0]            s3_den_reg;
    // Stage 4 state.
    logic                        s4_valid_reg, s4_outside_reg;
    logic [NCHAN-1:0][NUM_W-1:0] s4_num_reg;
    logic [DEN_W-1:0]            s4_den_reg;

    logic [CMP_W-1:0]   x_ext, y_ext;
    logic [FRAME_W-1:0] x_w, y_w;
    logic               outside_next;
    logic [FRAME_W-1:0] ax_next, bx_next, ay_next, by_next, dx_next, dy_next;
    logic [NCHAN-1:0][HSUM_W-1:0] top_next, bot_next;
    logic [NCHAN-1:0][NUM_W-1:0]  ptop_next, pbot_next, num_next;

    // Stage 1: range check and edge weights. A zero span puts all weight on the
    // left or top corner.
    always_comb
    begin
        x_ext        = CMP_W'(pixel_x);
        y_ext        = CMP_W'(pixel_y);
        x_w          = x_ext[FRAME_W-1:0];
        y_w          = y_ext[FRAME_W-1:0];
        outside_next = (x_ext >= CMP_W'(cfg.frame_width)) ||
                       (y_ext >= CMP_W'(cfg.frame_height));

        dx_next = cfg.frame_width - FRAME_W'(1);
        ax_next = dx_next - x_w;
        bx_next = x_w;
        if (dx_next == '0)
        begin
            ax_next = FRAME_W'(1);
            bx_next = '0;
            dx_next = FRAME_W'(1);
        end

        dy_next = cfg.frame_height - FRAME_W'(1);
        ay_next = dy_next - y_w;
        by_next = y_w;
        if (dy_next == '0)
        begin
            ay_next = FRAME_W'(1);
            by_next = '0;
            dy_next = FRAME_W'(1);
        end
    end

    // Stage 2: blend along the top and bottom rows for each channel.
    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            top_next[c] = HSUM_W'(cfg.top_left_rgb[c*CHAN_W +: CHAN_W]) * HSUM_W'(s1_ax_reg)
                        + HSUM_W'(cfg.top_right_rgb[c*CHAN_W +: CHAN_W]) * HSUM_W'(s1_bx_reg);
            bot_next[c] = HSUM_W'(cfg.bottom_left_rgb[c*CHAN_W +: CHAN_W]) * HSUM_W'(s1_ax_reg)
                        + HSUM_W'(cfg.bottom_right_rgb[c*CHAN_W +: CHAN_W]) * HSUM_W'(s1_bx_reg);
        end
    end

    // Stage 3 weights the row blends vertically; stage 4 adds them.
    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            ptop_next[c] = NUM_W'(s2_ay_reg) * NUM_W'(s2_top_reg[c]);
            pbot_next[c] = NUM_W'(s2_by_reg) * NUM_W'(s2_bot_reg[c]);
            num_next[c]  = s3_top_reg[c] + s3_bot_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_outside_reg <= outside_next;
            s1_ax_reg      <= ax_next;
            s1_bx_reg      <= bx_next;
            s1_ay_reg      <= ay_next;
            s1_by_reg      <= by_next;
            s1_dx_reg      <= dx_next;
            s1_dy_reg      <= dy_next;

            s2_outside_reg <= s1_outside_reg;
            s2_top_reg     <= top_next;
            s2_bot_reg     <= bot_next;
            s2_ay_reg      <= s1_ay_reg;
            s2_by_reg      <= s1_by_reg;
            s2_den_reg     <= DEN_W'(s1_dx_reg) * DEN_W'(s1_dy_reg);

            s3_outside_reg <= s2_outside_reg;
            s3_top_reg     <= ptop_next;
            s3_bot_reg     <= pbot_next;
            s3_den_reg     <= s2_den_reg;

            s4_outside_reg <= s3_outside_reg;
            s4_num_reg     <= num_next;
            s4_den_reg     <= s3_den_reg;
        end
    end

    assign fout.valid   = s4_valid_reg;
    assign fout.outside = s4_outside_reg;
    assign fout.num     = s4_num_reg;
    assign fout.den     = s4_den_reg;

endmodule

// File: rtl/bcg_divider.sv
// Restoring divider pipeline, one quotient bit per stage, all channels side by side.
module bcg_divider (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  bcg_pkg::front_t din,
    output bcg_pkg::div_t   dout
);
    import bcg_pkg::*;

    logic                        vld_reg  [QUO_W];
    logic                        oob_reg  [QUO_W];
    logic [NCHAN-1:0][QUO_W-1:0] quo_reg  [QUO_W];
    logic [NCHAN-1:0][NUM_W-1:0] rem_reg  [QUO_W-1];
    logic [DEN_W-1:0]            den_reg  [QUO_W-1];

    genvar i;
    for (i = 0; i < QUO_W; i++)
    begin : g_stage
        logic                        vld_in, oob_in;
        logic [NCHAN-1:0][NUM_W-1:0] rem_in;
        logic [NCHAN-1:0][QUO_W-1:0] quo_in, quo_next;
        logic [DEN_W-1:0]            den_in;
        logic [NUM_W-1:0]            trial;
        logic [NCHAN-1:0]            fits;

        if (i == 0)
        begin : g_first
            assign vld_in = din.valid;
            assign oob_in = din.outside;
            assign rem_in = din.num;
            assign quo_in = '0;
            assign den_in = din.den;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[i-1];
            assign oob_in = oob_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        // Quotient bit QUO_W-1-i is set when the shifted divisor still fits.
        always_comb
        begin
            trial    = NUM_W'(den_in) << (QUO_W - 1 - i);
            quo_next = quo_in;
            for (int c = 0; c < NCHAN; c++)
            begin
                fits[c]                    = rem_in[c] >= trial;
                quo_next[c][QUO_W - 1 - i] = fits[c];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                oob_reg[i] <= oob_in;
                quo_reg[i] <= quo_next;
            end
        end

        // The remainder and divisor are only needed by the stages that follow.
        if (i < QUO_W - 1)
        begin : g_carry
            logic [NCHAN-1:0][NUM_W-1:0] rem_next;

            always_comb
            begin
                for (int c = 0; c < NCHAN; c++)
                begin
                    rem_next[c] = fits[c] ? (rem_in[c] - trial) : rem_in[c];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign dout.valid   = vld_reg[QUO_W-1];
    assign dout.outside = oob_reg[QUO_W-1];
    assign dout.chan    = quo_reg[QUO_W-1];

endmodule
